@@ rtl/tkbt_pkg.sv @@
// Package for the tag-keyed best-time table: widths, codes and defaults.
package tkbt_pkg;

  localparam int unsigned ENTRIES_DEF = 256;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned TAG_W    = 40;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned IN_BITS  = OP_W + TAG_W + IDX_W + TIME_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = STATUS_W + IDX_W + TIME_W + 1;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd0;
  localparam logic [OP_W-1:0] OP_REGISTER = 2'd1;
  localparam logic [OP_W-1:0] OP_SUBMIT   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  localparam logic [TIME_W-1:0] TIME_INIT = {TIME_W{1'b1}};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    entry_index;
    logic [TIME_W-1:0]   old_best;
    logic                improved;
  } result_t;

endpackage

@@ rtl/tkbt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tkbt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tag_keyed_best_time_table_unit.sv @@
// Top level of the tag-keyed best-time table: sequencer, entry count and result register.
//
//   channel   dir   fields (lowest bit up)
//   s_axis    in    op, tag, index, race_time
//   m_axis    out   status, entry_index, old_best, improved
//
// Lookup scans the entries in order, one tag RAM read per cycle;
// register, submit and the unused op do not scan.
// One item is in work at a time; s_axis_tready is high only when the sequencer is idle.
// Reset clears the entry count and the sequencer; the RAMs are not cleared.
// A stalled m_axis holds the result; the finished item waits in its last state.
module tag_keyed_best_time_table_unit
  import tkbt_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // op, tag, index, race_time
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // status, entry_index, old_best, improved
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     scan_q, scan_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;

  logic [OP_W-1:0]   op_q;
  logic [TAG_W-1:0]  tag_q;
  logic [IDX_W-1:0]  idx_q;
  logic [TIME_W-1:0] time_q;
  result_t           res_q, res_d;

  logic              out_vld_q;
  result_t           out_q;

  logic              tag_we;
  logic              best_we;
  logic [AW-1:0]     best_waddr;
  logic [TIME_W-1:0] best_wdata;
  logic [TAG_W-1:0]  tag_rdata;
  logic [TIME_W-1:0] best_rdata;
  logic              in_acc;
  logic              out_free;
  logic              hit;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign hit           = rd_vld_q && (tag_rdata == tag_q);

  tkbt_ram #(
    .WIDTH (TAG_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (tag_q),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (tag_rdata)
  );

  tkbt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (ENTRIES)
  ) u_best_ram (
    .clk_i   (clk_i),
    .we_i    (best_we),
    .waddr_i (best_waddr),
    .wdata_i (best_wdata),
    .raddr_i (AW'(idx_q)),
    .rdata_o (best_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    scan_d     = scan_q;
    rd_vld_d   = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    res_d      = res_q;
    tag_we     = 1'b0;
    best_we    = 1'b0;
    best_waddr = AW'(idx_q);
    best_wdata = time_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        res_d   = '0;
        state_d = S_FIN;
        case (op_q)
          OP_LOOKUP: begin
            scan_d = '0;
            if (cnt_q == '0) begin
              res_d.status = ST_NOT_FOUND;
            end else begin
              state_d = S_SCAN;
            end
          end
          OP_REGISTER: begin
            if (cnt_q == CW'(ENTRIES)) begin
              res_d.status = ST_FULL;
            end else begin
              tag_we            = 1'b1;
              best_we           = 1'b1;
              best_waddr        = cnt_q[AW-1:0];
              best_wdata        = TIME_INIT;
              res_d.entry_index = IDX_W'(cnt_q);
              cnt_d             = cnt_q + CW'(1);
            end
          end
          OP_SUBMIT: begin
            res_d.entry_index = idx_q;
            if (XW'(idx_q) >= XW'(cnt_q)) begin
              res_d.status = ST_RANGE;
            end else begin
              state_d = S_SUB;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (scan_q < cnt_q) begin
          rd_vld_d  = 1'b1;
          cmp_idx_d = scan_q[AW-1:0];
          scan_d    = scan_q + CW'(1);
        end
        if (hit) begin
          res_d.entry_index = IDX_W'(cmp_idx_q);
          state_d           = S_FIN;
        end else if (rd_vld_q && (scan_q == cnt_q)) begin
          res_d.status = ST_NOT_FOUND;
          state_d      = S_FIN;
        end
      end
      S_SUB: begin
        if (time_q < best_rdata) begin
          best_we        = 1'b1;
          res_d.improved = 1'b1;
        end else begin
          res_d.old_best = best_rdata;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      scan_q    <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      scan_q   <= scan_d;
      rd_vld_q <= rd_vld_d;
      if ((state_q == S_FIN) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    if (in_acc) begin
      op_q   <= s_axis_tdata[OP_W-1:0];
      tag_q  <= s_axis_tdata[OP_W +: TAG_W];
      idx_q  <= s_axis_tdata[OP_W+TAG_W +: IDX_W];
      time_q <= s_axis_tdata[OP_W+TAG_W+IDX_W +: TIME_W];
    end
    if ((state_q == S_FIN) && out_free) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, out_q.improved, out_q.old_best,
                          out_q.entry_index, out_q.status};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_reg_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_we |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("register did not advance the entry count");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q != '0))
    else $error("scan of an empty table");

  a_improved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.improved) |-> (out_q.status == ST_DONE && out_q.old_best == '0))
    else $error("improved result carries a stale best or error");

endmodule
